FILE: src/sequence_loss_reorder_tracker_core_defines.svh
// assertion macros used by the tracker controller
`ifndef SEQUENCE_LOSS_REORDER_TRACKER_CORE_DEFINES_SVH
`define SEQUENCE_LOSS_REORDER_TRACKER_CORE_DEFINES_SVH

// condition implies consequence in the same cycle
`define SLRT_ASSERT_IMP(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// condition implies consequence in the next cycle
`define SLRT_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

FILE: src/slrt_pkg.sv
// package with shared types and constants of the tracker
package slrt_pkg;

  localparam int unsigned MAX_GAP_W   = 15;
  localparam int unsigned MAX_GAP_RST = 1000;
  localparam int unsigned CNT_W       = 32;
  localparam int unsigned TOTAL_W     = 17;

  typedef enum logic [2:0] {
    CLS_ON_TIME        = 3'd0,
    CLS_EARLY          = 3'd1,
    CLS_LATE_RECOVERED = 3'd2,
    CLS_LATE_DUPLICATE = 3'd3,
    CLS_UNREASONABLE   = 3'd4
  } arrival_class_e;

  typedef enum logic [1:0] {
    KIND_ON_TIME,
    KIND_EARLY,
    KIND_LATE,
    KIND_UNREAS
  } kind_e;

  typedef struct packed {
    logic accept;
    logic check;
    logic clr_wr;
    logic classify;
    logic fill_rd;
    logic fill_wr;
    logic prune_start;
    logic prune_rd;
    logic prune_wr;
    logic late_rd;
    logic late_wr;
    logic load_out;
  } slrt_cmd_t;

  typedef struct packed {
    logic  sender_diff;
    kind_e kind;
    logic  fill_last;
    logic  prune_need;
    logic  wcnt_last;
  } slrt_status_t;

endpackage

FILE: src/slrt_if.sv
// valid/ready channels for input and result items
interface slrt_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] seq_number;
  logic [63:0] sender_high;
  logic [63:0] sender_low;

  modport source (output valid, output seq_number, output sender_high, output sender_low,
                  input ready);
  modport sink (input valid, input seq_number, input sender_high, input sender_low,
                output ready);
endinterface

interface slrt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  arrival_class;
  logic        sender_changed;
  logic [31:0] received_count;
  logic [31:0] unreasonable_count;
  logic [31:0] early_count;
  logic [31:0] late_count;
  logic [31:0] lost_count;
  logic [31:0] recovered_count;
  logic [31:0] duplicate_count;
  logic [16:0] missing_total;

  modport source (output valid, output arrival_class, output sender_changed,
                  output received_count, output unreasonable_count, output early_count,
                  output late_count, output lost_count, output recovered_count,
                  output duplicate_count, output missing_total, input ready);
  modport sink (input valid, input arrival_class, input sender_changed,
                input received_count, input unreasonable_count, input early_count,
                input late_count, input lost_count, input recovered_count,
                input duplicate_count, input missing_total, output ready);
endinterface

FILE: src/slrt_ram.sv
// single port ram with registered read
module slrt_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: src/slrt_dp.sv
// datapath: counters, classification, bitmap word updates, result register
module slrt_dp #(
  parameter int unsigned SEQ_BITS      = 16,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  slrt_pkg::slrt_cmd_t                   cmd_i,
  output slrt_pkg::slrt_status_t                status_o,
  input  logic                                  max_gap_we_i,
  input  logic [slrt_pkg::MAX_GAP_W-1:0]        max_gap_wdata_i,
  input  logic [15:0]                           seq_number_i,
  input  logic [63:0]                           sender_high_i,
  input  logic [63:0]                           sender_low_i,
  output logic [2:0]                            arrival_class_o,
  output logic                                  sender_changed_o,
  output logic [slrt_pkg::CNT_W-1:0]            received_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            unreasonable_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            early_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            late_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            lost_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            recovered_count_o,
  output logic [slrt_pkg::CNT_W-1:0]            duplicate_count_o,
  output logic [slrt_pkg::TOTAL_W-1:0]          missing_total_o
);

  localparam int unsigned IDX_W   = $clog2(MAP_WORD_BITS);
  localparam int unsigned WADDR_W = SEQ_BITS - IDX_W;
  localparam int unsigned WORDS   = 1 << WADDR_W;
  localparam int unsigned DW      =
    ((SEQ_BITS > slrt_pkg::MAX_GAP_W) ? SEQ_BITS : slrt_pkg::MAX_GAP_W) + 3;
  localparam int unsigned CW      = IDX_W + 1;
  localparam int unsigned PW      = SEQ_BITS + 1;
  localparam int unsigned CNT_W   = slrt_pkg::CNT_W;

  localparam logic signed [DW-1:0] RNG = $signed(DW'(1) << SEQ_BITS);

  function automatic logic [CW-1:0] popcnt(input logic [MAP_WORD_BITS-1:0] v);
    logic [CW-1:0] s;
    s = '0;
    for (int i = 0; i < MAP_WORD_BITS; i++) begin
      s = s + CW'(v[i]);
    end
    return s;
  endfunction

  // item and sender state
  logic [SEQ_BITS-1:0]               seq_q;
  logic [63:0]                       sh_q, sl_q;
  logic [63:0]                       last_sh_q, last_sh_d, last_sl_q, last_sl_d;
  logic [SEQ_BITS-1:0]               last_seq_q, last_seq_d;
  logic [slrt_pkg::MAX_GAP_W-1:0]    max_gap_q;
  logic [CNT_W-1:0] rcv_q, rcv_d, unr_q, unr_d, early_q, early_d, late_q, late_d;
  logic [CNT_W-1:0] lost_q, lost_d, recov_q, recov_d, dup_q, dup_d;
  logic [PW-1:0]                     pop_q, pop_d;
  logic                              changed_q, changed_d;
  slrt_pkg::arrival_class_e          cls_q, cls_d;
  logic [SEQ_BITS-1:0]               cur_q, cur_d;
  logic [DW-1:0]                     rem_q, rem_d;
  logic [WADDR_W-1:0]                wcnt_q, wcnt_d;

  // result register
  logic [2:0]                        o_cls_q;
  logic                              o_chg_q;
  logic [CNT_W-1:0] o_rcv_q, o_unr_q, o_early_q, o_late_q, o_lost_q, o_recov_q, o_dup_q;
  logic [slrt_pkg::TOTAL_W-1:0]      o_tot_q;

  // classification
  logic [SEQ_BITS-1:0]   expected;
  logic signed [DW-1:0]  inc_s, exp_s, mg_s, gap_s, inc_a, exp_a, n_s;
  logic                  roll;
  slrt_pkg::kind_e       kind;

  // word updates
  logic [WADDR_W-1:0]        ram_addr;
  logic                      ram_we;
  logic [MAP_WORD_BITS-1:0]  ram_wdata, rdata;
  logic [IDX_W-1:0]          lo;
  logic [CW-1:0]             avail, take;
  logic [MAP_WORD_BITS-1:0]  fmask, drop, lmask;
  logic                      hit;
  logic signed [DW-1:0]      last_s, cut_s, cut_hi_s, m_s;

  assign expected = (rcv_q != '0) ? SEQ_BITS'(last_seq_q + 1'b1) : seq_q;
  assign inc_s    = $signed({{(DW-SEQ_BITS){1'b0}}, seq_q});
  assign exp_s    = $signed({{(DW-SEQ_BITS){1'b0}}, expected});
  assign mg_s     = $signed({{(DW-slrt_pkg::MAX_GAP_W){1'b0}}, max_gap_q});

  always_comb begin
    gap_s = (inc_s > exp_s) ? (inc_s - exp_s) : (exp_s - inc_s);
    roll  = (gap_s >= (RNG - mg_s));
    inc_a = inc_s;
    exp_a = exp_s;
    if (roll) begin
      if (inc_s > exp_s) begin
        inc_a = inc_s - RNG;
      end else begin
        exp_a = exp_s - RNG;
      end
    end
    n_s = inc_a - exp_a;
    if (seq_q == expected) begin
      kind = slrt_pkg::KIND_ON_TIME;
    end else if (!roll && (gap_s > mg_s)) begin
      kind = slrt_pkg::KIND_UNREAS;
    end else if (inc_a > exp_a) begin
      kind = slrt_pkg::KIND_EARLY;
    end else begin
      kind = slrt_pkg::KIND_LATE;
    end
  end

  // run of bits to mark in the current word
  assign lo    = cur_q[IDX_W-1:0];
  assign avail = CW'(MAP_WORD_BITS) - CW'(lo);
  assign take  = (rem_q < {{(DW-CW){1'b0}}, avail}) ? CW'(rem_q) : avail;
  assign fmask = ({MAP_WORD_BITS{1'b1}} >> (CW'(MAP_WORD_BITS) - take)) << lo;

  // age window around the last number
  assign last_s   = $signed({{(DW-SEQ_BITS){1'b0}}, last_seq_q});
  assign cut_s    = last_s - mg_s;
  assign cut_hi_s = cut_s + RNG;

  always_comb begin
    drop = '0;
    m_s  = '0;
    for (int b = 0; b < MAP_WORD_BITS; b++) begin
      m_s = $signed({{(DW-SEQ_BITS){1'b0}}, wcnt_q, IDX_W'(b)});
      if (cut_s >= 0) begin
        drop[b] = (m_s > last_s) || (m_s < cut_s);
      end else begin
        drop[b] = (m_s > last_s) && (m_s < cut_hi_s);
      end
    end
  end

  assign lmask = MAP_WORD_BITS'(1) << seq_q[IDX_W-1:0];
  assign hit   = |(rdata & lmask);

  always_comb begin
    ram_addr  = wcnt_q;
    ram_we    = 1'b0;
    ram_wdata = '0;
    if (cmd_i.fill_rd || cmd_i.fill_wr) begin
      ram_addr = cur_q[SEQ_BITS-1:IDX_W];
    end else if (cmd_i.late_rd || cmd_i.late_wr) begin
      ram_addr = seq_q[SEQ_BITS-1:IDX_W];
    end
    if (cmd_i.fill_wr) begin
      ram_we    = 1'b1;
      ram_wdata = rdata | fmask;
    end else if (cmd_i.prune_wr) begin
      ram_we    = 1'b1;
      ram_wdata = rdata & ~drop;
    end else if (cmd_i.late_wr) begin
      ram_we    = hit;
      ram_wdata = rdata & ~lmask;
    end else if (cmd_i.clr_wr) begin
      ram_we    = 1'b1;
    end
  end

  slrt_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (WORDS)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .addr_i  (ram_addr),
    .wdata_i (ram_wdata),
    .rdata_o (rdata)
  );

  always_comb begin
    last_sh_d  = last_sh_q;
    last_sl_d  = last_sl_q;
    last_seq_d = last_seq_q;
    rcv_d      = rcv_q;
    unr_d      = unr_q;
    early_d    = early_q;
    late_d     = late_q;
    lost_d     = lost_q;
    recov_d    = recov_q;
    dup_d      = dup_q;
    pop_d      = pop_q;
    changed_d  = changed_q;
    cls_d      = cls_q;
    cur_d      = cur_q;
    rem_d      = rem_q;
    wcnt_d     = wcnt_q;
    if (cmd_i.check) begin
      changed_d = status_o.sender_diff;
      wcnt_d    = '0;
      if (status_o.sender_diff) begin
        last_sh_d = sh_q;
        last_sl_d = sl_q;
        rcv_d     = '0;
        unr_d     = '0;
        early_d   = '0;
        late_d    = '0;
        lost_d    = '0;
        recov_d   = '0;
        dup_d     = '0;
        pop_d     = '0;
      end
    end
    if (cmd_i.clr_wr || cmd_i.prune_wr) begin
      wcnt_d = wcnt_q + 1'b1;
    end
    if (cmd_i.prune_start) begin
      wcnt_d = '0;
    end
    if (cmd_i.classify) begin
      rcv_d = rcv_q + 1'b1;
      unique case (kind)
        slrt_pkg::KIND_ON_TIME: begin
          last_seq_d = seq_q;
          cls_d      = slrt_pkg::CLS_ON_TIME;
        end
        slrt_pkg::KIND_UNREAS: begin
          unr_d = unr_q + 1'b1;
          cls_d = slrt_pkg::CLS_UNREASONABLE;
        end
        slrt_pkg::KIND_EARLY: begin
          cls_d      = slrt_pkg::CLS_EARLY;
          early_d    = early_q + 1'b1;
          lost_d     = lost_q + CNT_W'($unsigned(n_s));
          last_seq_d = seq_q;
          cur_d      = expected;
          rem_d      = $unsigned(n_s);
        end
        slrt_pkg::KIND_LATE: begin
          late_d = late_q + 1'b1;
        end
        default: begin
          cls_d = cls_q;
        end
      endcase
    end
    if (cmd_i.fill_wr) begin
      pop_d = pop_q + PW'(popcnt(fmask & ~rdata));
      cur_d = cur_q + SEQ_BITS'(take);
      rem_d = rem_q - DW'(take);
    end
    if (cmd_i.prune_wr) begin
      pop_d = pop_q - PW'(popcnt(rdata & drop));
    end
    if (cmd_i.late_wr) begin
      if (hit) begin
        pop_d   = pop_q - 1'b1;
        lost_d  = lost_q - 1'b1;
        recov_d = recov_q + 1'b1;
        cls_d   = slrt_pkg::CLS_LATE_RECOVERED;
      end else begin
        dup_d = dup_q + 1'b1;
        cls_d = slrt_pkg::CLS_LATE_DUPLICATE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_sh_q  <= '0;
      last_sl_q  <= '0;
      last_seq_q <= '1;
      max_gap_q  <= slrt_pkg::MAX_GAP_W'(slrt_pkg::MAX_GAP_RST);
      rcv_q      <= '0;
      unr_q      <= '0;
      early_q    <= '0;
      late_q     <= '0;
      lost_q     <= '0;
      recov_q    <= '0;
      dup_q      <= '0;
      pop_q      <= '0;
      changed_q  <= 1'b0;
      cls_q      <= slrt_pkg::CLS_ON_TIME;
      cur_q      <= '0;
      rem_q      <= '0;
      wcnt_q     <= '0;
    end else begin
      last_sh_q  <= last_sh_d;
      last_sl_q  <= last_sl_d;
      last_seq_q <= last_seq_d;
      if (max_gap_we_i) begin
        max_gap_q <= max_gap_wdata_i;
      end
      rcv_q      <= rcv_d;
      unr_q      <= unr_d;
      early_q    <= early_d;
      late_q     <= late_d;
      lost_q     <= lost_d;
      recov_q    <= recov_d;
      dup_q      <= dup_d;
      pop_q      <= pop_d;
      changed_q  <= changed_d;
      cls_q      <= cls_d;
      cur_q      <= cur_d;
      rem_q      <= rem_d;
      wcnt_q     <= wcnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      seq_q <= seq_number_i[SEQ_BITS-1:0];
      sh_q  <= sender_high_i;
      sl_q  <= sender_low_i;
    end
    if (cmd_i.load_out) begin
      o_cls_q   <= cls_q;
      o_chg_q   <= changed_q;
      o_rcv_q   <= rcv_q;
      o_unr_q   <= unr_q;
      o_early_q <= early_q;
      o_late_q  <= late_q;
      o_lost_q  <= lost_q;
      o_recov_q <= recov_q;
      o_dup_q   <= dup_q;
      o_tot_q   <= slrt_pkg::TOTAL_W'(pop_q);
    end
  end

  assign status_o.sender_diff = (sh_q != last_sh_q) || (sl_q != last_sl_q);
  assign status_o.kind        = kind;
  assign status_o.fill_last   = (rem_q <= {{(DW-CW){1'b0}}, avail});
  assign status_o.prune_need  = (DW'(pop_q) > DW'(max_gap_q));
  assign status_o.wcnt_last   = (wcnt_q == WADDR_W'(WORDS - 1));

  assign arrival_class_o      = o_cls_q;
  assign sender_changed_o     = o_chg_q;
  assign received_count_o     = o_rcv_q;
  assign unreasonable_count_o = o_unr_q;
  assign early_count_o        = o_early_q;
  assign late_count_o         = o_late_q;
  assign lost_count_o         = o_lost_q;
  assign recovered_count_o    = o_recov_q;
  assign duplicate_count_o    = o_dup_q;
  assign missing_total_o      = o_tot_q;

endmodule

FILE: src/slrt_ctrl.sv
// controller: sequences clear, classify, fill, prune and late steps
`include "sequence_loss_reorder_tracker_core_defines.svh"

module slrt_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  input  slrt_pkg::slrt_status_t status_i,
  output slrt_pkg::slrt_cmd_t    cmd_o
);

  localparam logic [3:0] S_RST_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE      = 4'd1;
  localparam logic [3:0] S_CHECK     = 4'd2;
  localparam logic [3:0] S_CHG_CLR   = 4'd3;
  localparam logic [3:0] S_CLASS     = 4'd4;
  localparam logic [3:0] S_FILL_RD   = 4'd5;
  localparam logic [3:0] S_FILL_WR   = 4'd6;
  localparam logic [3:0] S_PRUNE_CHK = 4'd7;
  localparam logic [3:0] S_PRUNE_RD  = 4'd8;
  localparam logic [3:0] S_PRUNE_WR  = 4'd9;
  localparam logic [3:0] S_LATE_RD   = 4'd10;
  localparam logic [3:0] S_LATE_WR   = 4'd11;
  localparam logic [3:0] S_RESULT    = 4'd12;

  logic [3:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '0;
    unique case (state_q)
      S_RST_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.wcnt_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.check = 1'b1;
        state_d     = status_i.sender_diff ? S_CHG_CLR : S_CLASS;
      end
      S_CHG_CLR: begin
        cmd_o.clr_wr = 1'b1;
        if (status_i.wcnt_last) state_d = S_CLASS;
      end
      S_CLASS: begin
        cmd_o.classify = 1'b1;
        unique case (status_i.kind)
          slrt_pkg::KIND_EARLY: state_d = S_FILL_RD;
          slrt_pkg::KIND_LATE:  state_d = S_LATE_RD;
          default:              state_d = S_RESULT;
        endcase
      end
      S_FILL_RD: begin
        cmd_o.fill_rd = 1'b1;
        state_d       = S_FILL_WR;
      end
      S_FILL_WR: begin
        cmd_o.fill_wr = 1'b1;
        state_d       = status_i.fill_last ? S_PRUNE_CHK : S_FILL_RD;
      end
      S_PRUNE_CHK: begin
        cmd_o.prune_start = 1'b1;
        state_d           = status_i.prune_need ? S_PRUNE_RD : S_RESULT;
      end
      S_PRUNE_RD: begin
        cmd_o.prune_rd = 1'b1;
        state_d        = S_PRUNE_WR;
      end
      S_PRUNE_WR: begin
        cmd_o.prune_wr = 1'b1;
        state_d        = status_i.wcnt_last ? S_RESULT : S_PRUNE_RD;
      end
      S_LATE_RD: begin
        cmd_o.late_rd = 1'b1;
        state_d       = S_LATE_WR;
      end
      S_LATE_WR: begin
        cmd_o.late_wr = 1'b1;
        state_d       = S_RESULT;
      end
      S_RESULT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_RST_CLR;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  `SLRT_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == S_CHECK, "accepted item did not start sender check")
  `SLRT_ASSERT_NEXT(a_result_loaded, clk_i, rst_ni, (state_q == S_RESULT) && !out_valid_q, out_valid_q && (state_q == S_IDLE), "finished item not presented")
  `SLRT_ASSERT_IMP(a_one_writer, clk_i, rst_ni, 1'b1, $onehot0({cmd_o.fill_wr, cmd_o.prune_wr, cmd_o.late_wr, cmd_o.clr_wr}), "two bitmap writers at once")

endmodule

FILE: src/sequence_loss_reorder_tracker_core.sv
// top level of the sequence loss and reorder tracker
//
// channel   dir  handshake      payload
// in_i      in   valid/ready    seq_number, sender_high, sender_low
// out_o     out  valid/ready    arrival_class, sender_changed, seven counters, missing_total
// max_gap   in   we only        max_gap_wdata_i (15 bits)
//
// one item at a time; on time and unreasonable items pass accept, check, classify and result
// steps, late items add a bitmap read and write; an early item adds a read and write per bitmap
// word touched by the gap fill and a prune check, and a prune reads and writes every bitmap word
// a new sender adds a clear of the bitmap, one word per cycle through the ram port
// after reset the same clearing pass runs over all 2^SEQ_BITS / MAP_WORD_BITS words before
// the first item is taken; a result waiting in the output register does not stall input,
// the next item holds in its result step until the waiting result is taken
module sequence_loss_reorder_tracker_core #(
  parameter int unsigned SEQ_BITS      = 16,
  parameter int unsigned MAP_WORD_BITS = 32
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           max_gap_we_i,
  input  logic [slrt_pkg::MAX_GAP_W-1:0] max_gap_wdata_i,
  slrt_in_if.sink                        in_i,
  slrt_out_if.source                     out_o
);

  // command and status between controller and datapath
  slrt_pkg::slrt_cmd_t    cmd;
  slrt_pkg::slrt_status_t status;

  // controller owns the handshakes and the result valid
  slrt_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // datapath holds counters, the missing bitmap ram and the result payload
  slrt_dp #(
    .SEQ_BITS      (SEQ_BITS),
    .MAP_WORD_BITS (MAP_WORD_BITS)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .status_o             (status),
    .max_gap_we_i         (max_gap_we_i),
    .max_gap_wdata_i      (max_gap_wdata_i),
    .seq_number_i         (in_i.seq_number),
    .sender_high_i        (in_i.sender_high),
    .sender_low_i         (in_i.sender_low),
    .arrival_class_o      (out_o.arrival_class),
    .sender_changed_o     (out_o.sender_changed),
    .received_count_o     (out_o.received_count),
    .unreasonable_count_o (out_o.unreasonable_count),
    .early_count_o        (out_o.early_count),
    .late_count_o         (out_o.late_count),
    .lost_count_o         (out_o.lost_count),
    .recovered_count_o    (out_o.recovered_count),
    .duplicate_count_o    (out_o.duplicate_count),
    .missing_total_o      (out_o.missing_total)
  );

endmodule

FILE: tb/sequence_loss_reorder_tracker_core_test.sv
// self-checking testbench of the sequence loss and reorder tracker
`timescale 1ns / 1ps

module sequence_loss_reorder_tracker_core_test;

  localparam int SEQ_SPAN    = 65536;
  localparam int CYCLE_LIMIT = 100_000_000;

  // counter slots, in the order of the result fields
  localparam int CNT_RECEIVED     = 0;
  localparam int CNT_UNREASONABLE = 1;
  localparam int CNT_EARLY        = 2;
  localparam int CNT_LATE         = 3;
  localparam int CNT_LOST         = 4;
  localparam int CNT_RECOVERED    = 5;
  localparam int CNT_DUPLICATE    = 6;
  localparam int CNT_NUM          = 7;

  typedef struct {
    slrt_pkg::arrival_class_e cls;
    bit                       changed;
    bit [31:0]                cnt [CNT_NUM];
    bit [16:0]                total;
  } tally_t;

  typedef struct {
    bit [15:0]                seq;
    bit [63:0]                hi;
    bit [63:0]                lo;
    bit                       typed;
    slrt_pkg::arrival_class_e cls;
  } packet_row_t;

  logic clk_i;
  logic rst_ni;
  logic max_gap_we_i;
  logic [slrt_pkg::MAX_GAP_W-1:0] max_gap_wdata_i;

  slrt_in_if  in_if ();
  slrt_out_if out_if ();

  sequence_loss_reorder_tracker_core u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .max_gap_we_i    (max_gap_we_i),
    .max_gap_wdata_i (max_gap_wdata_i),
    .in_i            (in_if),
    .out_o           (out_if)
  );

  // tracker state as the testbench sees it
  bit        miss_map [SEQ_SPAN];
  int        miss_pop;
  bit [15:0] last_seq;
  bit [63:0] last_hi;
  bit [63:0] last_lo;
  bit [31:0] stats [CNT_NUM];
  int        gap_limit;

  tally_t tally_q [$];
  int     err_count;
  int     cycle_count;
  bit     quiet;

  // short directed run: first packet, every class, seq extremes and wrap
  packet_row_t dir_rows [14] = '{
    '{16'd5,     64'h0, 64'h0, 1'b1, slrt_pkg::CLS_ON_TIME},
    '{16'd6,     64'h0, 64'h0, 1'b1, slrt_pkg::CLS_ON_TIME},
    '{16'd10,    64'h0, 64'h0, 1'b1, slrt_pkg::CLS_EARLY},
    '{16'd8,     64'h0, 64'h0, 1'b1, slrt_pkg::CLS_LATE_RECOVERED},
    '{16'd8,     64'h0, 64'h0, 1'b1, slrt_pkg::CLS_LATE_DUPLICATE},
    '{16'd5000,  64'h0, 64'h0, 1'b1, slrt_pkg::CLS_UNREASONABLE},
    '{16'd65535, 64'h0, 64'h0, 1'b1, slrt_pkg::CLS_LATE_DUPLICATE},
    '{16'd0,     64'h0, 64'h0, 1'b0, slrt_pkg::CLS_ON_TIME},
    '{16'd65530, '1,    '1,    1'b1, slrt_pkg::CLS_ON_TIME},
    '{16'd2,     '1,    '1,    1'b1, slrt_pkg::CLS_EARLY},
    '{16'd65533, '1,    '1,    1'b1, slrt_pkg::CLS_LATE_RECOVERED},
    '{16'd0,     '1,    '1,    1'b1, slrt_pkg::CLS_LATE_RECOVERED},
    '{16'd3,     '1,    64'h0, 1'b1, slrt_pkg::CLS_ON_TIME},
    '{16'd700,   '1,    64'h0, 1'b0, slrt_pkg::CLS_ON_TIME}
  };

  // clock
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  function automatic void clear_tracking();
    foreach (miss_map[i]) miss_map[i] = 1'b0;
    miss_pop = 0;
    foreach (stats[i]) stats[i] = '0;
  endfunction

  function automatic void mark_missing(int n);
    if (!miss_map[n]) begin
      miss_map[n] = 1'b1;
      miss_pop++;
    end
  endfunction

  // drop missing numbers outside the age window behind the last number
  function automatic void age_out();
    int last;
    int cutoff;
    bit drop;
    last = last_seq;
    cutoff = last - gap_limit;
    for (int m = 0; m < SEQ_SPAN; m++) begin
      if (miss_map[m]) begin
        if (cutoff >= 0) drop = (m > last) || (m < cutoff);
        else drop = (m > last) && (m < cutoff + SEQ_SPAN);
        if (drop) begin
          miss_map[m] = 1'b0;
          miss_pop--;
        end
      end
    end
  endfunction

  // classify one packet and update the tracked state
  function automatic tally_t track_packet(bit [15:0] seq, bit [63:0] hi, bit [63:0] lo);
    tally_t t;
    int inc;
    int exq;
    int gap;
    bit skip;
    t.cls = slrt_pkg::CLS_ON_TIME;
    t.changed = 1'b0;
    skip = 1'b0;
    if (hi != last_hi || lo != last_lo) begin
      clear_tracking();
      last_hi = hi;
      last_lo = lo;
      t.changed = 1'b1;
    end
    inc = seq;
    exq = (stats[CNT_RECEIVED] != 0) ? int'(16'(last_seq + 16'd1)) : inc;
    stats[CNT_RECEIVED]++;
    if (inc == exq) begin
      last_seq = seq;
    end else begin
      gap = (inc > exq) ? inc - exq : exq - inc;
      if (gap >= SEQ_SPAN - gap_limit) begin
        // wrapped around the sequence space
        if (inc > exq) inc -= SEQ_SPAN;
        else exq -= SEQ_SPAN;
      end else if (gap > gap_limit) begin
        stats[CNT_UNREASONABLE]++;
        t.cls = slrt_pkg::CLS_UNREASONABLE;
        skip = 1'b1;
      end
      if (!skip) begin
        if (inc > exq) begin
          t.cls = slrt_pkg::CLS_EARLY;
          stats[CNT_EARLY]++;
          stats[CNT_LOST] += 32'(inc - exq);
          last_seq = seq;
          for (int k = exq; k < inc; k++) mark_missing((k < 0) ? k + SEQ_SPAN : k);
          if (miss_pop > gap_limit) age_out();
        end else begin
          stats[CNT_LATE]++;
          if (miss_map[seq]) begin
            miss_map[seq] = 1'b0;
            miss_pop--;
            stats[CNT_LOST]--;
            stats[CNT_RECOVERED]++;
            t.cls = slrt_pkg::CLS_LATE_RECOVERED;
          end else begin
            stats[CNT_DUPLICATE]++;
            t.cls = slrt_pkg::CLS_LATE_DUPLICATE;
          end
        end
      end
    end
    t.cnt = stats;
    t.total = 17'(miss_pop);
    return t;
  endfunction

  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    if (got != want) begin
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      err_count++;
    end
  endtask

  // result side: random stall bursts, none once quiet
  int stall_left;
  always @(negedge clk_i) begin
    if (quiet) begin
      out_if.ready <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_if.ready <= 1'b0;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 4) - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk_i) begin
    tally_t w;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (tally_q.size() == 0) begin
        $display("mismatch: result item with nothing expected at %0t", $realtime);
        err_count++;
      end else begin
        w = tally_q.pop_front();
        report_mismatch("arrival_class", out_if.arrival_class, w.cls);
        report_mismatch("sender_changed", out_if.sender_changed, w.changed);
        report_mismatch("received_count", out_if.received_count, w.cnt[CNT_RECEIVED]);
        report_mismatch("unreasonable_count", out_if.unreasonable_count,
                        w.cnt[CNT_UNREASONABLE]);
        report_mismatch("early_count", out_if.early_count, w.cnt[CNT_EARLY]);
        report_mismatch("late_count", out_if.late_count, w.cnt[CNT_LATE]);
        report_mismatch("lost_count", out_if.lost_count, w.cnt[CNT_LOST]);
        report_mismatch("recovered_count", out_if.recovered_count, w.cnt[CNT_RECOVERED]);
        report_mismatch("duplicate_count", out_if.duplicate_count, w.cnt[CNT_DUPLICATE]);
        report_mismatch("missing_total", out_if.missing_total, w.total);
      end
    end
  end

  // send one packet, predict it once accepted; starts and ends on a falling edge
  task automatic send_packet(bit [15:0] seq, bit [63:0] hi, bit [63:0] lo,
                             bit typed, slrt_pkg::arrival_class_e tcls);
    tally_t t;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk_i);
    end
    in_if.valid       <= 1'b1;
    in_if.seq_number  <= seq;
    in_if.sender_high <= hi;
    in_if.sender_low  <= lo;
    do @(posedge clk_i); while (!in_if.ready);
    t = track_packet(seq, hi, lo);
    if (typed) t.cls = tcls;
    tally_q.push_back(t);
    @(negedge clk_i);
  endtask

  // let every result drain with the input idle
  task automatic drain_results();
    in_if.valid <= 1'b0;
    @(negedge clk_i);
    while (tally_q.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_max_gap(int value);
    drain_results();
    max_gap_we_i    <= 1'b1;
    max_gap_wdata_i <= slrt_pkg::MAX_GAP_W'(value);
    gap_limit = value;
    @(negedge clk_i);
    max_gap_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  // one packet of the random mix, mostly a well-behaved stream
  task automatic send_random(inout bit [63:0] hi, inout bit [63:0] lo);
    int r;
    int span;
    bit [15:0] seq;
    r = $urandom_range(0, 99);
    seq = last_seq + 16'd1;
    if (r < 65) begin
      // in order
    end else if (r < 76) begin
      seq = last_seq + 16'd1 + 16'($urandom_range(1, (gap_limit < 8) ? gap_limit : 8));
    end else if (r < 78) begin
      // long gap fill
      seq = last_seq + 16'd1 + 16'($urandom_range(1, gap_limit));
    end else if (r < 89) begin
      seq = last_seq - 16'($urandom_range(0, 30));
    end else if (r < 93) begin
      span = SEQ_SPAN - 2 * gap_limit - 2;
      if (span >= 0)
        seq = last_seq + 16'd1 + 16'(gap_limit + 1 + $urandom_range(0, (span < 100) ? span : 100));
    end else if (r < 98) begin
      seq = 16'($urandom);
    end else begin
      // new sender
      hi = {$urandom, $urandom};
      lo = {$urandom, $urandom};
      if ($urandom_range(0, 3) == 0) hi = $urandom_range(0, 1) ? '1 : '0;
    end
    send_packet(seq, hi, lo, 1'b0, slrt_pkg::CLS_ON_TIME);
  endtask

  initial begin
    int phase_gap [5];
    int phase_len [5];
    bit [63:0] cur_hi;
    bit [63:0] cur_lo;
    int sent;

    rst_ni             = 1'b0;
    max_gap_we_i       = 1'b0;
    max_gap_wdata_i    = '0;
    in_if.valid        = 1'b0;
    in_if.seq_number   = '0;
    in_if.sender_high  = '0;
    in_if.sender_low   = '0;
    out_if.ready       = 1'b0;
    quiet              = 1'b0;
    err_count          = 0;
    cycle_count        = 0;
    stall_left         = 0;

    clear_tracking();
    last_seq  = 16'hFFFF;
    last_hi   = '0;
    last_lo   = '0;
    gap_limit = slrt_pkg::MAX_GAP_RST;

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (dir_rows[i])
      send_packet(dir_rows[i].seq, dir_rows[i].hi, dir_rows[i].lo,
                  dir_rows[i].typed, dir_rows[i].cls);

    // phases of max_gap, extremes included; the tightest one is kept short
    // because nearly every early packet there costs a full bitmap prune
    phase_gap = '{32767, 1, $urandom_range(2, 200), 300, slrt_pkg::MAX_GAP_RST};
    phase_len = '{425, 150, 425, 425, 425};
    cur_hi = {$urandom, $urandom};
    cur_lo = {$urandom, $urandom};
    sent = 0;
    foreach (phase_gap[p]) begin
      write_max_gap(phase_gap[p]);
      for (int n = 0; n < phase_len[p]; n++) begin
        if (p == 0 && n == 100) drain_results();
        if (sent == 1600) quiet = 1'b1;
        send_random(cur_hi, cur_lo);
        sent++;
      end
    end

    drain_results();
    repeat (50) @(posedge clk_i);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+src
src/slrt_pkg.sv
src/slrt_if.sv
src/slrt_ram.sv
src/slrt_dp.sv
src/slrt_ctrl.sv
src/sequence_loss_reorder_tracker_core.sv
tb/sequence_loss_reorder_tracker_core_test.sv
